/* rtl/rrtq_pkg.sv */
// types, codes and defaults for the request retry transaction queue
// no dependencies
package rrtq_pkg;

    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int PERIODIC_SLOTS_DEF = 8;
    localparam int HEADER_BYTES_DEF   = 9;

    localparam logic [15:0] TPS_RST      = 16'd100;
    localparam logic [7:0]  TIMEOUT_RST  = 8'd3;
    localparam logic [7:0]  RETRY_RST    = 8'd3;
    localparam logic [6:0]  NOTIFY_RST   = 7'd6;
    localparam logic [7:0]  MSG_ID_RST   = 8'd107;
    localparam logic [9:0]  MAX_LEN_RST  = 10'd256;

    localparam int ERR_FLAG_BIT = 7;
    localparam int RSP_ODD_BIT  = 0;
    localparam logic [7:0] TRY_MAX = 8'hFF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_REQUEST  = 2'd0,
        CMD_PERIODIC = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_INCOMING = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_SEND   = 2'd1,
        KIND_REPORT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_SUCCESS = 2'd0,
        ST_FAILURE = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TPS     = 3'd0,
        CFG_TIMEOUT = 3'd1,
        CFG_RETRY   = 3'd2,
        CFG_NOTIFY  = 3'd3,
        CFG_MSG_ID  = 3'd4,
        CFG_MAX_LEN = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_EVAL,
        S_PRD,
        S_PCHK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] object_id;
        logic [7:0]  op_type;
        logic [7:0]  param_ref;
        logic [9:0]  param_length;
        logic [15:0] repeat_seconds;
        logic        stop_if_error;
        logic [7:0]  message_id;
        logic [15:0] payload_length;
        logic [31:0] now_ticks;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic        accepted;
        logic [1:0]  status;
        logic [15:0] out_object_id;
        logic [7:0]  out_op_type;
        logic [7:0]  out_param_ref;
        logic [9:0]  out_param_length;
    } t_out_item;

endpackage

/* rtl/rrtq_ram.sv */
// simple dual port ram, one write and one registered read per cycle
// no dependencies
module rrtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rrtq_ctrl.sv */
// sequencer: queue head handling, periodic table walk, responses, config
// uses rrtq_pkg; drives the queue ram and the insert time ram
module rrtq_ctrl
    import rrtq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
    parameter int PERIODIC_SLOTS = PERIODIC_SLOTS_DEF,
    parameter int HEADER_BYTES   = HEADER_BYTES_DEF,
    parameter int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    parameter int SLOT_W = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1,
    parameter int ENT_W  = 43 + SLOT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    output logic                  o_fifo_we,
    output logic [PTR_W-1:0]      o_fifo_waddr,
    output logic [ENT_W-1:0]      o_fifo_wdata,
    output logic [PTR_W-1:0]      o_fifo_raddr,
    input  logic [ENT_W-1:0]      i_fifo_rdata,
    output logic                  o_time_we,
    output logic [SLOT_W-1:0]     o_time_waddr,
    output logic [31:0]           o_time_wdata,
    output logic [SLOT_W-1:0]     o_time_raddr,
    input  logic [31:0]           i_time_rdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_state r_state, n_state;

    logic [15:0] r_tps;
    logic [7:0]  r_timeout;
    logic [7:0]  r_retry;
    logic [6:0]  r_notify;
    logic [7:0]  r_msg_id;
    logic [9:0]  r_max_len;

    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_try, n_try;
    logic [31:0]      r_sent, n_sent;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic             r_res_pend, n_res_pend;
    logic             r_out_valid, n_out_valid;

    t_in_item  r_item;
    t_out_item r_res, n_res;
    t_out_item r_out_item, n_out_item;
    logic [23:0] r_limit;
    logic [31:0] r_rep_lim;

    logic        r_pv   [PERIODIC_SLOTS];
    logic        r_ps   [PERIODIC_SLOTS];
    logic        r_pe   [PERIODIC_SLOTS];
    logic        r_pst  [PERIODIC_SLOTS];
    logic [15:0] r_prep [PERIODIC_SLOTS];
    logic [15:0] r_pobj [PERIODIC_SLOTS];
    logic [7:0]  r_pop  [PERIODIC_SLOTS];
    logic [7:0]  r_pref [PERIODIC_SLOTS];
    logic [9:0]  r_plen [PERIODIC_SLOTS];
    logic        n_pv   [PERIODIC_SLOTS];
    logic        n_ps   [PERIODIC_SLOTS];
    logic        n_pe   [PERIODIC_SLOTS];

    logic [15:0] h_obj;
    logic [7:0]  h_op;
    logic [7:0]  h_pref;
    logic [9:0]  h_len;
    logic        h_per;
    logic [SLOT_W-1:0] h_slot;

    logic              push_req;
    logic [ENT_W-1:0]  push_data;
    logic              push_ok;
    logic [PTR_W:0]    wpos_sum;
    logic [PTR_W-1:0]  wpos;
    logic              eval_res;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic              timed_out;
    logic [6:0]        base;
    logic              last_slot;

    assign {h_obj, h_op, h_pref, h_len, h_per, h_slot} = i_fifo_rdata;

    assign o_cfg_ready  = 1'b1;
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_item   = r_out_item;
    assign o_fifo_raddr = r_rd_ptr;
    assign o_time_raddr = r_slot;

    assign push_ok   = push_req && (push_data[SLOT_W+1 +: 10] <= r_max_len)
                       && (r_count < CNT_W'(QUEUE_DEPTH));
    assign wpos_sum  = {1'b0, r_rd_ptr} + (PTR_W+1)'(r_count);
    assign wpos      = (wpos_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                       PTR_W'(wpos_sum - (PTR_W+1)'(QUEUE_DEPTH)) : PTR_W'(wpos_sum);
    assign o_fifo_we    = push_ok;
    assign o_fifo_waddr = wpos;
    assign o_fifo_wdata = push_data;

    assign timed_out = (r_item.now_ticks - r_sent) >= {8'd0, r_limit};
    assign base      = r_item.op_type[6:0];
    assign last_slot = (r_slot == SLOT_W'(PERIODIC_SLOTS - 1));

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = PERIODIC_SLOTS - 1; i >= 0; i--) begin
            if (!r_pv[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: n_state = S_EVAL;
            S_EVAL: begin
                if (r_item.cmd == CMD_TICK) begin
                    n_state = S_PRD;
                end else if (eval_res) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PRD: n_state = S_PCHK;
            S_PCHK: begin
                if (last_slot) begin
                    n_state = r_res_pend ? S_OUT : S_IDLE;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_rd_ptr    = r_rd_ptr;
        n_count     = r_count;
        n_try       = r_try;
        n_sent      = r_sent;
        n_slot      = r_slot;
        n_res_pend  = r_res_pend;
        n_res       = r_res;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid;
        n_pv        = r_pv;
        n_ps        = r_ps;
        n_pe        = r_pe;
        push_req    = 1'b0;
        push_data   = '0;
        eval_res    = 1'b0;
        o_time_we    = 1'b0;
        o_time_waddr = r_slot;
        o_time_wdata = r_item.now_ticks;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_EVAL: begin
                n_res      = '0;
                n_res_pend = 1'b0;
                n_slot     = '0;
                case (r_item.cmd)
                    CMD_REQUEST: begin
                        push_req  = 1'b1;
                        push_data = {r_item.object_id, r_item.op_type, r_item.param_ref,
                                     r_item.param_length, 1'b0, SLOT_W'(0)};
                        n_res.kind     = KIND_ACCEPT;
                        n_res.accepted = push_ok;
                        eval_res       = 1'b1;
                        if (push_ok) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    CMD_PERIODIC: begin
                        n_res.kind = KIND_ACCEPT;
                        eval_res   = 1'b1;
                        if (r_item.param_length <= r_max_len && free_found) begin
                            n_res.accepted  = 1'b1;
                            n_pv[free_slot] = 1'b1;
                            n_ps[free_slot] = 1'b0;
                            n_pe[free_slot] = 1'b0;
                        end
                    end
                    CMD_TICK: begin
                        if (r_count != '0) begin
                            n_res.out_object_id    = h_obj;
                            n_res.out_op_type      = h_op;
                            n_res.out_param_ref    = h_pref;
                            n_res.out_param_length = h_len;
                            if (r_try >= r_retry && timed_out) begin
                                n_res.kind   = KIND_REPORT;
                                n_res.status = ST_TIMEOUT;
                                n_res_pend   = 1'b1;
                                n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ?
                                           '0 : r_rd_ptr + 1'b1;
                                n_count  = r_count - 1'b1;
                                n_try    = '0;
                                n_sent   = '0;
                            end else if (r_try == '0 || timed_out) begin
                                n_res.kind = KIND_SEND;
                                n_res_pend = 1'b1;
                                if (r_try != TRY_MAX) begin
                                    n_try = r_try + 1'b1;
                                end
                                n_sent = r_item.now_ticks;
                            end
                        end
                    end
                    CMD_INCOMING: begin
                        n_res.kind             = KIND_REPORT;
                        n_res.out_object_id    = r_item.object_id;
                        n_res.out_op_type      = r_item.op_type;
                        n_res.out_param_ref    = r_item.param_ref;
                        n_res.out_param_length = r_item.param_length;
                        if (r_item.message_id == r_msg_id &&
                            r_item.payload_length >= 16'(HEADER_BYTES) &&
                            r_item.param_length <= r_max_len) begin
                            if (base == r_notify) begin
                                n_res.status = ST_SUCCESS;
                                eval_res     = 1'b1;
                            end else if (!base[RSP_ODD_BIT] && base < r_notify &&
                                         r_count != '0 && (h_op + 8'd1) == {1'b0, base} &&
                                         h_obj == r_item.object_id) begin
                                if (h_per && ({1'b0, h_slot} < (SLOT_W+1)'(PERIODIC_SLOTS))
                                    && r_pst[h_slot]) begin
                                    n_pe[h_slot] = r_item.op_type[ERR_FLAG_BIT];
                                end
                                n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ?
                                           '0 : r_rd_ptr + 1'b1;
                                n_count  = r_count - 1'b1;
                                n_try    = '0;
                                n_sent   = '0;
                                n_res.status = r_item.op_type[ERR_FLAG_BIT] ?
                                               ST_FAILURE : ST_SUCCESS;
                                eval_res = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_PCHK: begin
                n_slot = last_slot ? '0 : r_slot + 1'b1;
                if (r_pv[r_slot] && !(r_pst[r_slot] && r_pe[r_slot])) begin
                    if (!r_ps[r_slot] || (r_item.now_ticks - i_time_rdata) >= r_rep_lim) begin
                        push_req  = 1'b1;
                        push_data = {r_pobj[r_slot], r_pop[r_slot], r_pref[r_slot],
                                     r_plen[r_slot], 1'b1, r_slot};
                        if (push_ok) begin
                            n_count = r_count + 1'b1;
                        end
                        o_time_we = 1'b1;
                    end
                    n_ps[r_slot] = 1'b1;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_item  = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_try       <= '0;
            r_sent      <= '0;
            r_slot      <= '0;
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tps       <= TPS_RST;
            r_timeout   <= TIMEOUT_RST;
            r_retry     <= RETRY_RST;
            r_notify    <= NOTIFY_RST;
            r_msg_id    <= MSG_ID_RST;
            r_max_len   <= MAX_LEN_RST;
            for (int i = 0; i < PERIODIC_SLOTS; i++) begin
                r_pv[i] <= 1'b0;
                r_ps[i] <= 1'b0;
                r_pe[i] <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_try       <= n_try;
            r_sent      <= n_sent;
            r_slot      <= n_slot;
            r_res_pend  <= n_res_pend;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
            r_ps        <= n_ps;
            r_pe        <= n_pe;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TPS:     r_tps     <= i_cfg_data;
                    CFG_TIMEOUT: r_timeout <= i_cfg_data[7:0];
                    CFG_RETRY:   r_retry   <= i_cfg_data[7:0];
                    CFG_NOTIFY:  r_notify  <= i_cfg_data[6:0];
                    CFG_MSG_ID:  r_msg_id  <= i_cfg_data[7:0];
                    CFG_MAX_LEN: r_max_len <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_out_item <= n_out_item;
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in_item;
        end
        if (r_state == S_HEAD) begin
            r_limit <= r_timeout * r_tps;
        end
        if (r_state == S_PRD) begin
            r_rep_lim <= r_prep[r_slot] * r_tps;
        end
        if (r_state == S_EVAL && r_item.cmd == CMD_PERIODIC && free_found) begin
            r_pst[free_slot]  <= r_item.stop_if_error;
            r_prep[free_slot] <= r_item.repeat_seconds;
            r_pobj[free_slot] <= r_item.object_id;
            r_pop[free_slot]  <= r_item.op_type;
            r_pref[free_slot] <= r_item.param_ref;
            r_plen[free_slot] <= r_item.param_length;
        end
    end

endmodule

/* rtl/request_retry_transaction_queue.sv */
// channel    direction  signals
// in         sink       i_in_valid, o_in_stall, i_in_item
// out        source     o_out_valid, i_out_stall, o_out_item
// cfg        sink       i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
// request, add periodic and incoming transactions pass through the head and
// eval states, then the output state loads the output register when there is a
// result; a tick also walks the periodic table in the read and check states, one slot per
// insert time ram read. reset is synchronous; no clearing pass is needed.
// a stalled output holds the finished result; one more transaction is taken.
// top level: queue ram, insert time ram and sequencer; uses rrtq_pkg
module request_retry_transaction_queue
    import rrtq_pkg::*;
#(
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
    parameter int PERIODIC_SLOTS = PERIODIC_SLOTS_DEF,
    parameter int HEADER_BYTES   = HEADER_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SLOT_W = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1;
    localparam int ENT_W  = 43 + SLOT_W;

    logic              fifo_we;
    logic [PTR_W-1:0]  fifo_waddr;
    logic [ENT_W-1:0]  fifo_wdata;
    logic [PTR_W-1:0]  fifo_raddr;
    logic [ENT_W-1:0]  fifo_rdata;
    logic              time_we;
    logic [SLOT_W-1:0] time_waddr;
    logic [31:0]       time_wdata;
    logic [SLOT_W-1:0] time_raddr;
    logic [31:0]       time_rdata;

    rrtq_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH), .AW(PTR_W)) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (fifo_waddr),
        .i_wdata (fifo_wdata),
        .i_raddr (fifo_raddr),
        .o_rdata (fifo_rdata)
    );

    rrtq_ram #(.WIDTH(32), .DEPTH(PERIODIC_SLOTS), .AW(SLOT_W)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (time_we),
        .i_waddr (time_waddr),
        .i_wdata (time_wdata),
        .i_raddr (time_raddr),
        .o_rdata (time_rdata)
    );

    rrtq_ctrl #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .PERIODIC_SLOTS (PERIODIC_SLOTS),
        .HEADER_BYTES   (HEADER_BYTES),
        .PTR_W          (PTR_W),
        .SLOT_W         (SLOT_W),
        .ENT_W          (ENT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_item   (o_out_item),
        .o_fifo_we    (fifo_we),
        .o_fifo_waddr (fifo_waddr),
        .o_fifo_wdata (fifo_wdata),
        .o_fifo_raddr (fifo_raddr),
        .i_fifo_rdata (fifo_rdata),
        .o_time_we    (time_we),
        .o_time_waddr (time_waddr),
        .o_time_wdata (time_wdata),
        .o_time_raddr (time_raddr),
        .i_time_rdata (time_rdata)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// self-checking bench for request_retry_transaction_queue: queue, retry, periodic
// and incoming-message behaviour checked against an in-bench predictor; uses rrtq_pkg
module tb_top;
    import rrtq_pkg::*;

    localparam int QDEPTH = QUEUE_DEPTH_DEF;
    localparam int PSLOTS = PERIODIC_SLOTS_DEF;
    localparam int HDR = HEADER_BYTES_DEF;
    localparam longint CYCLE_LIMIT = 2000000;

    logic i_clk, i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_stall;
    t_in_item i_in_item;
    logic o_out_valid;
    logic i_out_stall;
    t_out_item o_out_item;

    request_retry_transaction_queue uut (.*);

    typedef struct {
        logic [15:0] obj;
        logic [7:0] op;
        logic [7:0] pref;
        logic [9:0] plen;
        bit periodic;
        int slot;
    } t_req;

    typedef struct {
        bit valid, sent, errored, stop;
        logic [15:0] rpt, obj;
        logic [7:0] op, pref;
        logic [9:0] plen;
    } t_prd;

    logic [15:0] tps;
    logic [7:0] tmo, retry_lim, msg_id;
    logic [6:0] notify_op;
    logic [9:0] max_len;
    t_req reqs[QDEPTH];
    int rd_ptr, q_count;
    int try_count;
    logic [31:0] sent_at;
    t_prd prd[PSLOTS];
    logic [31:0] prd_time[PSLOTS];
    logic [31:0] now;

    t_out_item expected_q[$];
    int errors;
    longint cycles;
    bit rx_hold;
    int idle_pct;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic t_out_item mk(t_kind k, bit acc, t_status st, logic [15:0] o,
                                     logic [7:0] op, logic [7:0] r, logic [9:0] l);
        t_out_item t;
        t.kind = k; t.accepted = acc; t.status = st;
        t.out_object_id = o; t.out_op_type = op; t.out_param_ref = r;
        t.out_param_length = l;
        return t;
    endfunction

    function automatic bit push_req(logic [15:0] o, logic [7:0] op, logic [7:0] r,
                                    logic [9:0] l, bit per, int s);
        int pos;
        if (l > max_len || q_count >= QDEPTH) return 1'b0;
        pos = (rd_ptr + q_count) % QDEPTH;
        reqs[pos] = '{o, op, r, l, per, s};
        q_count++;
        return 1'b1;
    endfunction

    function automatic void pop_req();
        rd_ptr = (rd_ptr + 1) % QDEPTH;
        q_count--;
        try_count = 0;
        sent_at = '0;
    endfunction

    function automatic void predict(t_in_item it);
        t_req h;
        logic [31:0] lim;
        bit tmd, ok, e;
        logic [6:0] base;
        case (t_cmd'(it.cmd))
            CMD_REQUEST: expected_q.push_back(mk(KIND_ACCEPT,
                push_req(it.object_id, it.op_type, it.param_ref, it.param_length, 1'b0, 0),
                ST_SUCCESS, '0, '0, '0, '0));
            CMD_PERIODIC: begin
                ok = 1'b0;
                if (it.param_length <= max_len)
                    for (int i = 0; i < PSLOTS && !ok; i++)
                        if (!prd[i].valid) begin
                            prd[i] = '{1'b1, 1'b0, 1'b0, it.stop_if_error,
                                       it.repeat_seconds, it.object_id, it.op_type,
                                       it.param_ref, it.param_length};
                            ok = 1'b1;
                        end
                expected_q.push_back(mk(KIND_ACCEPT, ok, ST_SUCCESS, '0, '0, '0, '0));
            end
            CMD_TICK: begin
                if (q_count > 0) begin
                    h = reqs[rd_ptr];
                    lim = 32'(tmo) * 32'(tps);
                    tmd = (it.now_ticks - sent_at) >= lim;
                    if (try_count >= retry_lim && tmd) begin
                        expected_q.push_back(mk(KIND_REPORT, 1'b0, ST_TIMEOUT, h.obj, h.op,
                                                h.pref, h.plen));
                        pop_req();
                    end else if (try_count == 0 || tmd) begin
                        expected_q.push_back(mk(KIND_SEND, 1'b0, ST_SUCCESS, h.obj, h.op,
                                                h.pref, h.plen));
                        if (try_count < 255) try_count++;
                        sent_at = it.now_ticks;
                    end
                end
                for (int i = 0; i < PSLOTS; i++) begin
                    if (!prd[i].valid || (prd[i].stop && prd[i].errored)) continue;
                    if (!prd[i].sent ||
                        (it.now_ticks - prd_time[i]) >= 32'(prd[i].rpt) * 32'(tps)) begin
                        void'(push_req(prd[i].obj, prd[i].op, prd[i].pref, prd[i].plen,
                                       1'b1, i));
                        prd_time[i] = it.now_ticks;
                    end
                    prd[i].sent = 1'b1;
                end
            end
            CMD_INCOMING: begin
                if (it.message_id != msg_id || it.payload_length < 16'(HDR) ||
                    it.param_length > max_len) return;
                e = it.op_type[7];
                base = it.op_type[6:0];
                if (base == notify_op) begin
                    expected_q.push_back(mk(KIND_REPORT, 1'b0, ST_SUCCESS, it.object_id,
                                            it.op_type, it.param_ref, it.param_length));
                end else if (!base[0] && base < notify_op && q_count > 0) begin
                    h = reqs[rd_ptr];
                    if (8'(h.op + 8'd1) == {1'b0, base} && h.obj == it.object_id) begin
                        if (h.periodic && prd[h.slot].stop) prd[h.slot].errored = e;
                        pop_req();
                        expected_q.push_back(mk(KIND_REPORT, 1'b0,
                            e ? ST_FAILURE : ST_SUCCESS, it.object_id, it.op_type,
                            it.param_ref, it.param_length));
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // result checker and receiver stall
    always @(posedge i_clk) begin
        t_out_item x;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) report("result with nothing expected");
            else begin
                x = expected_q.pop_front();
                if (o_out_item.kind !== x.kind) report("kind");
                if (o_out_item.accepted !== x.accepted) report("accepted");
                if (o_out_item.status !== x.status) report("status");
                if (o_out_item.out_object_id !== x.out_object_id) report("object id");
                if (o_out_item.out_op_type !== x.out_op_type) report("op type");
                if (o_out_item.out_param_ref !== x.out_param_ref) report("param ref");
                if (o_out_item.out_param_length !== x.out_param_length)
                    report("param length");
            end
        end
    end

    always @(negedge i_clk)
        i_out_stall <= rx_hold || ($urandom_range(99) < idle_pct);

    // valid stays high between back to back transactions and drops when idling
    task automatic send(t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_item <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] d);
        i_cfg_index <= idx;
        i_cfg_data <= d;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TPS: tps = d;
            CFG_TIMEOUT: tmo = d[7:0];
            CFG_RETRY: retry_lim = d[7:0];
            CFG_NOTIFY: notify_op = d[6:0];
            CFG_MSG_ID: msg_id = d[7:0];
            CFG_MAX_LEN: max_len = d[9:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic t_in_item item(t_cmd c, logic [15:0] o, logic [7:0] op,
                                      logic [9:0] l);
        t_in_item it;
        it = '{default: '0};
        it.cmd = c; it.object_id = o; it.op_type = op; it.param_length = l;
        it.param_ref = 8'($urandom); it.repeat_seconds = 16'($urandom_range(3));
        it.stop_if_error = 1'($urandom); it.message_id = msg_id;
        it.payload_length = 16'($urandom_range(HDR, 65535));
        it.now_ticks = now;
        return it;
    endfunction

    function automatic t_in_item tick(int adv);
        now += 32'(adv);
        return item(CMD_TICK, 16'($urandom), 8'($urandom), 10'($urandom));
    endfunction

    // answers the current head when the queue is not empty, sometimes with the error flag
    function automatic t_in_item answer();
        logic [7:0] op;
        t_in_item it;
        op = q_count > 0 ? 8'(reqs[rd_ptr].op + 8'd1) : 8'($urandom_range(127));
        op[7] = $urandom_range(3) == 0;
        it = item(CMD_INCOMING, q_count > 0 ? reqs[rd_ptr].obj : 16'($urandom), op,
                  10'($urandom_range(max_len)));
        return it;
    endfunction

    function automatic t_in_item noise();
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom}));
        if ($urandom_range(1)) it.message_id = msg_id;
        it.now_ticks = now;
        return it;
    endfunction

    task automatic test_directed();
        t_in_item it;
        send(item(CMD_REQUEST, 16'hFFFF, 8'h02, 10'd256));
        send(item(CMD_REQUEST, 16'h0000, 8'hFF, 10'd257));
        send(item(CMD_REQUEST, 16'h1234, 8'h7F, 10'd0));
        it = item(CMD_PERIODIC, 16'h0042, 8'h00, 10'd5);
        it.stop_if_error = 1'b1; it.repeat_seconds = 16'hFFFF;
        send(it);
        send(item(CMD_PERIODIC, 16'd1, 8'd2, 10'd1023));
        send(tick(1));
        send(tick(1));
        send(tick(300));
        send(tick(300));
        send(tick(300));
        send(tick(300));
        it = item(CMD_INCOMING, 16'h1234, 8'h80, 10'd4); // base opcode zero with the error flag set
        send(it);
        it = item(CMD_INCOMING, 16'd5, {1'b1, notify_op}, 10'd3);
        send(it);
        it = item(CMD_INCOMING, 16'd5, 8'd2, 10'd3); it.message_id = 8'(msg_id + 8'd1);
        send(it);
        it = item(CMD_INCOMING, 16'd5, 8'd2, 10'd3); it.payload_length = 16'(HDR - 1);
        send(it);
        it = item(CMD_INCOMING, 16'd5, 8'd2, 10'd1023);
        send(it);
        send(answer());
        send(tick(1));
        send(answer());
        now = 32'hFFFF_FFF0;
        send(tick(0));
        send(tick(400));
        drain();
    endtask

    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 25) send(item(CMD_REQUEST, 16'($urandom_range(7)),
                                  8'($urandom_range(2) * 2),
                                  10'($urandom_range(max_len + 2))));
            else if (r < 30) send(item(CMD_PERIODIC, 16'($urandom_range(7)),
                                       8'($urandom_range(2) * 2),
                                       10'($urandom_range(max_len))));
            else if (r < 60) send(tick($urandom_range(2) == 0 ? int'($urandom) :
                                       int'($urandom_range(200))));
            else if (r < 90) send(answer());
            else send(noise());
        end
    endtask

    task automatic test_full();
        fork
            begin
                rx_hold = 1;
                repeat (400) @(negedge i_clk);
                rx_hold = 0;
            end
            for (int i = 0; i < 20; i++) send(item(CMD_REQUEST, 16'(i), 8'd2, 10'd1));
        join
        drain();
        for (int i = 0; i < 40; i++) send(tick(0));
        drain();
    endtask

    task automatic set_cfg(logic [15:0] t, logic [7:0] to, logic [7:0] rl,
                           logic [6:0] no, logic [7:0] mi, logic [9:0] ml);
        cfg_write(CFG_TPS, t); cfg_write(CFG_TIMEOUT, 16'(to)); cfg_write(CFG_RETRY, 16'(rl));
        cfg_write(CFG_NOTIFY, 16'(no)); cfg_write(CFG_MSG_ID, 16'(mi));
        cfg_write(CFG_MAX_LEN, 16'(ml));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        errors = 0; cycles = 0; rx_hold = 0; idle_pct = 7; now = 0;
        i_rst_n = 0; i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        i_in_valid = 0; i_in_item = '0; i_out_stall = 0;
        tps = TPS_RST; tmo = TIMEOUT_RST; retry_lim = RETRY_RST; notify_op = NOTIFY_RST;
        msg_id = MSG_ID_RST; max_len = MAX_LEN_RST;
        rd_ptr = 0; q_count = 0; try_count = 0; sent_at = 0;
        for (int i = 0; i < PSLOTS; i++) begin
            prd[i] = '{default: '0};
            prd_time[i] = 0;
        end
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        test_directed();
        test_full();
        test_random(500);
        drain();
        set_cfg(16'd1, 8'd1, 8'd1, 7'd127, 8'd0, 10'd1023);
        test_random(350);
        drain();
        idle_pct = 0;
        set_cfg(16'hFFFF, 8'hFF, 8'hFF, 7'd0, 8'hFF, 10'd0);
        test_random(200);
        drain();
        idle_pct = 7;
        set_cfg(16'd10, 8'd2, 8'd2, 7'd9, 8'h5A, 10'd300);
        test_random(800);
        drain();
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule

/* files.f */
rtl/rrtq_pkg.sv
rtl/rrtq_ram.sv
rtl/rrtq_ctrl.sv
rtl/request_retry_transaction_queue.sv
tb/tb_top.sv
